@@ src/mcpg_pkg.sv @@
// Package for the midpoint circle pixel generator.
// Holds widths, the job record passed from front to back, and the pixel
// order helper. No dependencies.
package mcpg_pkg;

   localparam int CoordW     = 8;
   localparam int ColorW     = 4;
   localparam int DecW       = 12;
   localparam int StepXW     = 10;
   localparam int StepYW     = 11;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);
   localparam int BeatW      = 3;

   localparam logic [BeatW-1:0] START_LAST_BEAT = 3'd3;
   localparam logic [BeatW-1:0] STEP_LAST_BEAT  = 3'd7;

   typedef enum logic [1:0] {
      JOB_START,
      JOB_STEP,
      JOB_IDLE
   } job_kind_type;

   // One accepted item after classification and state update
   typedef struct packed {
      job_kind_type             kind;
      logic [CoordW-1:0]        cx;
      logic [CoordW-1:0]        cy;
      logic [CoordW-1:0]        x;
      logic [CoordW-1:0]        y;
      logic [ColorW-1:0]        color;
      logic                     done;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Octant pattern: bit 2 swaps x/y, bit 0 negates column term,
   // bit 1 negates row term. Start beats use the axis subset.
   function automatic logic [BeatW-1:0] start_pattern(input logic [1:0] beat);
      logic [BeatW-1:0] p;
      case (beat)
         2'd0: p = 3'd0;
         2'd1: p = 3'd2;
         2'd2: p = 3'd4;
         2'd3: p = 3'd5;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

endpackage

@@ src/mcpg_if.sv @@
// Handshake channel interfaces for the midpoint circle pixel generator.
// Depends on mcpg_pkg for field widths.
interface mcpg_req_if import mcpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [CoordW-1:0]    center_x;
   logic [CoordW-1:0]    center_y;
   logic [CoordW-1:0]    radius;
   logic [ColorW-1:0]    paint;

   modport source (output valid, cmd, center_x, center_y, radius, paint, input ready);
   modport sink   (input valid, cmd, center_x, center_y, radius, paint, output ready);
endinterface

interface mcpg_rsp_if import mcpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CoordW-1:0]    pixel_x;
   logic [CoordW-1:0]    pixel_y;
   logic [ColorW-1:0]    pixel_color;
   logic                 pixel_valid;
   logic                 done_res;
   logic                 last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, done_res, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, done_res, last,
                   output ready);
endinterface

@@ src/mcpg_front.sv @@
// Front end: accepts commands, runs the midpoint decision update and
// pushes one job per item. Depends on mcpg_pkg and mcpg_req_if.
module mcpg_front import mcpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mcpg_req_if.sink         req_ch,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic [CoordW-1:0] cur_x_ff, cur_x_in;
   logic [CoordW-1:0] cur_y_ff, cur_y_in;
   logic [DecW-1:0]   decision_ff, decision_in;
   logic [StepXW-1:0] step_x_ff, step_x_in;
   logic [StepYW-1:0] step_y_ff, step_y_in;
   logic [CoordW-1:0] held_cx_ff, held_cx_in;
   logic [CoordW-1:0] held_cy_ff, held_cy_in;
   logic [ColorW-1:0] held_color_ff, held_color_in;

   logic [StepYW-1:0] sy_inc;
   logic [DecW-1:0]   dec_a;
   logic [StepXW-1:0] sx_inc;
   logic [CoordW-1:0] y_a;
   logic [CoordW-1:0] x_inc;

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      sy_inc = step_y_ff + StepYW'(2);
      sx_inc = step_x_ff + StepXW'(2);
      x_inc  = cur_x_ff + CoordW'(1);
      if (!decision_ff[DecW-1]) begin
         y_a   = cur_y_ff - CoordW'(1);
         dec_a = decision_ff + {sy_inc[StepYW-1], sy_inc};
      end else begin
         y_a   = cur_y_ff;
         dec_a = decision_ff;
      end

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      decision_in   = decision_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      held_cx_in    = held_cx_ff;
      held_cy_in    = held_cy_ff;
      held_color_in = held_color_ff;

      push_job.kind  = JOB_IDLE;
      push_job.cx    = held_cx_ff;
      push_job.cy    = held_cy_ff;
      push_job.x     = cur_x_ff;
      push_job.y     = cur_y_ff;
      push_job.color = held_color_ff;
      push_job.done  = 1'b1;

      if (!req_ch.cmd) begin
         held_cx_in    = req_ch.center_x;
         held_cy_in    = req_ch.center_y;
         held_color_in = req_ch.paint;
         cur_x_in      = '0;
         cur_y_in      = req_ch.radius;
         decision_in   = DecW'(1) - {4'b0, req_ch.radius};
         step_x_in     = '0;
         step_y_in     = StepYW'(0) - {2'b0, req_ch.radius, 1'b0};
         push_job.kind  = JOB_START;
         push_job.cx    = req_ch.center_x;
         push_job.cy    = req_ch.center_y;
         push_job.x     = '0;
         push_job.y     = req_ch.radius;
         push_job.color = req_ch.paint;
         push_job.done  = (req_ch.radius == '0);
      end else if (cur_x_ff < cur_y_ff) begin
         cur_x_in    = x_inc;
         cur_y_in    = y_a;
         step_x_in   = sx_inc;
         step_y_in   = decision_ff[DecW-1] ? step_y_ff : sy_inc;
         decision_in = dec_a + {2'b0, sx_inc} + DecW'(1);
         push_job.kind = JOB_STEP;
         push_job.x    = x_inc;
         push_job.y    = y_a;
         push_job.done = (x_inc >= y_a);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         decision_ff   <= '0;
         step_x_ff     <= '0;
         step_y_ff     <= '0;
         held_cx_ff    <= '0;
         held_cy_ff    <= '0;
         held_color_ff <= '0;
      end else if (push) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         decision_ff   <= decision_in;
         step_x_ff     <= step_x_in;
         step_y_ff     <= step_y_in;
         held_cx_ff    <= held_cx_in;
         held_cy_ff    <= held_cy_in;
         held_color_ff <= held_color_in;
      end
   end

endmodule

@@ src/mcpg_queue.sv @@
// Short job queue between front and back ends.
// Depends on mcpg_pkg for the job record and depth.
module mcpg_queue import mcpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/mcpg_back.sv @@
// Back end: walks the head job one pixel per beat into the output register.
// Depends on mcpg_pkg and mcpg_rsp_if.
module mcpg_back import mcpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   mcpg_rsp_if.source       rsp_ch
);

   logic [BeatW-1:0]  beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CoordW-1:0] px_ff, px_in;
   logic [CoordW-1:0] py_ff, py_in;
   logic [ColorW-1:0] color_ff, color_in;
   logic              pvalid_ff, pvalid_in;
   logic              done_ff, done_in;
   logic              last_ff, last_in;

   logic              load;
   logic [BeatW-1:0]  pattern;
   logic [CoordW-1:0] a_term;
   logic [CoordW-1:0] b_term;

   assign load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      pattern = (head.kind == JOB_START) ? start_pattern(beat_ff[1:0]) : beat_ff;
      a_term  = pattern[2] ? head.y : head.x;
      b_term  = pattern[2] ? head.x : head.y;

      px_in     = pattern[0] ? head.cx - a_term : head.cx + a_term;
      py_in     = pattern[1] ? head.cy - b_term : head.cy + b_term;
      color_in  = head.color;
      pvalid_in = 1'b1;
      done_in   = head.done;
      case (head.kind)
         JOB_START: last_in = (beat_ff == START_LAST_BEAT);
         JOB_STEP:  last_in = (beat_ff == STEP_LAST_BEAT);
         JOB_IDLE: begin
            last_in   = 1'b1;
            px_in     = '0;
            py_in     = '0;
            color_in  = '0;
            pvalid_in = 1'b0;
            done_in   = 1'b1;
         end
         default: begin
            last_in   = 1'b1;
            px_in     = '0;
            py_in     = '0;
            color_in  = '0;
            pvalid_in = 1'b0;
            done_in   = 1'b1;
         end
      endcase

      pop          = load && !q_status.empty && last_in;
      rsp_valid_in = load ? !q_status.empty : rsp_valid_ff;
      beat_in      = beat_ff;
      if (load && !q_status.empty) begin
         beat_in = last_in ? '0 : beat_ff + BeatW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_status.empty) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         color_ff  <= color_in;
         pvalid_ff <= pvalid_in;
         done_ff   <= done_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_x     = px_ff;
   assign rsp_ch.pixel_y     = py_ff;
   assign rsp_ch.pixel_color = color_ff;
   assign rsp_ch.pixel_valid = pvalid_ff;
   assign rsp_ch.done_res    = done_ff;
   assign rsp_ch.last        = last_ff;

endmodule

@@ src/midpoint_circle_pixel_generator.sv @@
// Midpoint circle pixel generator top level.
// Uses mcpg_pkg, mcpg_if, mcpg_front, mcpg_queue and mcpg_back.
//
// Usage:
//   req_ch carries commands: cmd 0 starts a circle (center, radius, paint),
//   cmd 1 advances one midpoint step. rsp_ch carries pixels, one per cycle
//   while rsp_ch.ready is high, with last marking the final pixel of each command.
//   A start gives 4 pixels, a step 8 pixels, a step after the circle is
//   finished one empty result (pixel_valid 0, done_res 1).
//   With the queue and output register free, an accepted command is written
//   into the queue and its first pixel is then loaded into the output register.
//   Throughput: one pixel a cycle while rsp_ch.ready is high.
//   The front updates the decision state on accept and queues up to 2 jobs,
//   so commands are taken while the back end is still emitting pixels.
//   Reset clears the circle state (a step right after reset reports done)
//   and empties the queue and output register.
//   When rsp_ch.ready is low the output holds its pixel; once the queue is
//   full, req_ch.ready drops until the back end frees an entry.
module midpoint_circle_pixel_generator import mcpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mcpg_req_if.sink    req_ch,
   mcpg_rsp_if.source  rsp_ch
);

   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head;
   queue_status_type q_status;

   mcpg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   mcpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   mcpg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ src/mcpg_checker.sv @@
// Port-level checks for the midpoint circle pixel generator.
// Bound to midpoint_circle_pixel_generator; depends on mcpg_pkg.
module mcpg_checker import mcpg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CoordW-1:0] rsp_pixel_x,
   input logic [CoordW-1:0] rsp_pixel_y,
   input logic [ColorW-1:0] rsp_pixel_color,
   input logic              rsp_pixel_valid,
   input logic              rsp_done_res,
   input logic              rsp_last
);

   // Output register comes up empty after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last))
      else $error("stalled result changed");

   // Empty result only comes from a finished circle and stands alone
   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_done_res && rsp_last)
      else $error("empty result without done and last");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_color == '0)
      else $error("empty result carries nonzero fields");

endmodule

bind midpoint_circle_pixel_generator mcpg_checker u_mcpg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_x     (rsp_ch.pixel_x),
   .rsp_pixel_y     (rsp_ch.pixel_y),
   .rsp_pixel_color (rsp_ch.pixel_color),
   .rsp_pixel_valid (rsp_ch.pixel_valid),
   .rsp_done_res    (rsp_ch.done_res),
   .rsp_last        (rsp_ch.last)
);

@@ dv/midpoint_circle_pixel_generator_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the midpoint circle pixel generator: tracks the circle state
// from accepted commands and compares every emitted pixel against it.
// Depends on mcpg_pkg and the channel interfaces in mcpg_if.
package mcpg_tb_pkg;
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;
endpackage

module midpoint_circle_pixel_generator_checker
   import mcpg_pkg::*;
   import mcpg_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mcpg_req_if         req_mon,
   mcpg_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pixels_pending,
   output int unsigned pixels_checked
);

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [ColorW-1:0] color;
      logic              valid;
      logic              done;
      logic              last;
   } pixel_type;

   pixel_type expected_pixels[$];

   // circle state as the block should hold it
   logic [CoordW-1:0] off_x, off_y, org_x, org_y;
   logic [ColorW-1:0] ink;
   logic [DecW-1:0]   dterm;
   logic [StepXW-1:0] dx_inc;
   logic [StepYW-1:0] dy_inc;

   initial begin
      fail_count = 0;
      pixels_pending = 0;
      pixels_checked = 0;
      off_x = '0; off_y = '0; org_x = '0; org_y = '0;
      ink = '0; dterm = '0; dx_inc = '0; dy_inc = '0;
   end

   task automatic add_pixel(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                            input logic v, input logic d, input logic l);
      pixel_type p;
      p.x     = v ? px : '0;
      p.y     = v ? py : '0;
      p.color = v ? ink : '0;
      p.valid = v;
      p.done  = d;
      p.last  = l;
      expected_pixels.push_back(p);
   endtask

   task automatic rasterize_item(input logic cmd, input logic [CoordW-1:0] cx,
                                 input logic [CoordW-1:0] cy, input logic [CoordW-1:0] r,
                                 input logic [ColorW-1:0] paint);
      logic fin;
      if (cmd == CMD_START) begin
         org_x  = cx;
         org_y  = cy;
         ink    = paint;
         off_x  = '0;
         off_y  = r;
         dterm  = 12'd1 - {4'b0, r};
         dx_inc = '0;
         dy_inc = 11'd0 - {2'b0, r, 1'b0};
         fin    = (r == '0);
         add_pixel(org_x, org_y + r, 1'b1, fin, 1'b0);
         add_pixel(org_x, org_y - r, 1'b1, fin, 1'b0);
         add_pixel(org_x + r, org_y, 1'b1, fin, 1'b0);
         add_pixel(org_x - r, org_y, 1'b1, fin, 1'b1);
      end else if (off_x >= off_y) begin
         // circle finished (or never started): one empty result
         add_pixel('0, '0, 1'b0, 1'b1, 1'b1);
      end else begin
         if (!dterm[DecW-1]) begin
            off_y  = off_y - 1'b1;
            dy_inc = dy_inc + 11'd2;
            dterm  = dterm + {dy_inc[StepYW-1], dy_inc};
         end
         off_x  = off_x + 1'b1;
         dx_inc = dx_inc + 10'd2;
         dterm  = dterm + {2'b0, dx_inc} + 12'd1;
         fin    = (off_x >= off_y);
         add_pixel(org_x + off_x, org_y + off_y, 1'b1, fin, 1'b0);
         add_pixel(org_x - off_x, org_y + off_y, 1'b1, fin, 1'b0);
         add_pixel(org_x + off_x, org_y - off_y, 1'b1, fin, 1'b0);
         add_pixel(org_x - off_x, org_y - off_y, 1'b1, fin, 1'b0);
         add_pixel(org_x + off_y, org_y + off_x, 1'b1, fin, 1'b0);
         add_pixel(org_x - off_y, org_y + off_x, 1'b1, fin, 1'b0);
         add_pixel(org_x + off_y, org_y - off_x, 1'b1, fin, 1'b0);
         add_pixel(org_x - off_y, org_y - off_x, 1'b1, fin, 1'b1);
      end
   endtask

   task automatic compare_field(input string name, input int unsigned exp_v,
                                input int unsigned got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            rasterize_item(req_mon.cmd, req_mon.center_x, req_mon.center_y,
                           req_mon.radius, req_mon.paint);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result item with no expected pixel pending");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("pixel_x", 32'(want.x), 32'(rsp_mon.pixel_x));
               compare_field("pixel_y", 32'(want.y), 32'(rsp_mon.pixel_y));
               compare_field("pixel_color", 32'(want.color), 32'(rsp_mon.pixel_color));
               compare_field("pixel_valid", 32'(want.valid), 32'(rsp_mon.pixel_valid));
               compare_field("done_res", 32'(want.done), 32'(rsp_mon.done_res));
               compare_field("last", 32'(want.last), 32'(rsp_mon.last));
               pixels_checked++;
            end
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

@@ dv/midpoint_circle_pixel_generator_tb.sv @@
`timescale 1ns / 1ps
// Top of the midpoint circle pixel generator testbench: clock, reset, command
// stimulus and result back-pressure; checking is done in the checker module.
// Depends on mcpg_pkg, mcpg_tb_pkg, mcpg_if and the block itself.
module midpoint_circle_pixel_generator_tb;
   import mcpg_pkg::*;
   import mcpg_tb_pkg::*;

   localparam int ItemTarget = 460;

   logic        clock;
   logic        reset;
   logic        stall_on;
   int unsigned fail_count, pixels_pending, pixels_checked;
   int unsigned n_items, n_starts, n_steps;

   mcpg_req_if req_ch ();
   mcpg_rsp_if rsp_ch ();

   midpoint_circle_pixel_generator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   midpoint_circle_pixel_generator_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending),
      .pixels_checked (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("midpoint_circle_pixel_generator_tb: errors");
      $finish;
   end

   // result back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= stall_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
      end
   end

   task automatic send_item(input logic cmd, input logic [CoordW-1:0] cx,
                            input logic [CoordW-1:0] cy, input logic [CoordW-1:0] r,
                            input logic [ColorW-1:0] paint);
      logic taken;
      @(negedge clock);
      while (stall_on && $urandom_range(0, 99) < 33) begin
         req_ch.valid    <= 1'b0;
         req_ch.cmd      <= 1'($urandom_range(0, 1));
         req_ch.center_x <= CoordW'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.center_x <= cx;
      req_ch.center_y <= cy;
      req_ch.radius   <= r;
      req_ch.paint    <= paint;
      do begin
         @(posedge clock);
         taken = req_ch.ready;
      end while (!taken);
      n_items++;
      if (cmd == CMD_START) n_starts++;
      else n_steps++;
   endtask

   task automatic start_circle(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                               input logic [CoordW-1:0] r, input logic [ColorW-1:0] paint);
      send_item(CMD_START, cx, cy, r, paint);
   endtask

   // step items carry junk in the unused fields
   task automatic step_circle(input int count);
      repeat (count)
         send_item(CMD_STEP, CoordW'($urandom_range(0, 255)),
                   CoordW'($urandom_range(0, 255)), CoordW'($urandom_range(0, 255)),
                   ColorW'($urandom_range(0, 15)));
   endtask

   initial begin
      int r, steps;
      reset = 1'b1;
      stall_on = 1'b1;
      n_items = 0; n_starts = 0; n_steps = 0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_START;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.radius = '0;
      req_ch.paint = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: step before any start, zero radius, full-range wrap, tiny circles
      step_circle(1);
      start_circle(8'd0, 8'd0, 8'd0, 4'd0);
      step_circle(1);
      start_circle(8'd255, 8'd255, 8'd255, 4'd15);
      step_circle(3);
      start_circle(8'd0, 8'd0, 8'd255, 4'd10);
      step_circle(1);
      start_circle(8'd128, 8'd128, 8'd1, 4'd5);
      step_circle(2);
      start_circle(8'd10, 8'd20, 8'd2, 4'd3);
      step_circle(3);
      start_circle(8'd100, 8'd50, 8'd5, 4'd1);
      step_circle(2);
      // restart in the middle of a circle
      start_circle(8'd200, 8'd7, 8'd3, 4'd14);
      step_circle(3);

      // random circles, mostly run to completion
      while (n_items < ItemTarget) begin
         stall_on = !(n_items > 150 && n_items < 300);
         if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 255);
         else r = $urandom_range(0, 24);
         if ($urandom_range(0, 9) < 7) steps = (r * 3) / 4 + $urandom_range(1, 3);
         else steps = $urandom_range(0, r);
         // keep the total close to the target
         if (n_items + 1 + steps > ItemTarget + 20)
            steps = ItemTarget + 20 - n_items - 1;
         if ($urandom_range(0, 19) == 0)
            step_circle($urandom_range(1, 3));
         start_circle(CoordW'($urandom_range(0, 255)), CoordW'($urandom_range(0, 255)),
                      CoordW'(r), ColorW'($urandom_range(0, 15)));
         step_circle(steps);
      end
      stall_on = 1'b1;

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d circle starts and %0d step commands, %0d result items compared",
               n_starts, n_steps, pixels_checked);
      if (fail_count == 0)
         $display("midpoint_circle_pixel_generator_tb: clean");
      else
         $display("midpoint_circle_pixel_generator_tb: errors");
      $finish;
   end

endmodule

@@ midpoint_circle_pixel_generator.f @@
src/mcpg_pkg.sv
src/mcpg_if.sv
src/mcpg_front.sv
src/mcpg_queue.sv
src/mcpg_back.sv
src/midpoint_circle_pixel_generator.sv
src/mcpg_checker.sv
dv/midpoint_circle_pixel_generator_checker.sv
dv/midpoint_circle_pixel_generator_tb.sv
